[rtl/lsb_stego_embed_extract_defines.svh]
// ----------------------------------------------------------------------------
// LSB stego assertion macros
// Shared concurrent assertion forms for the stego block checkers.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define LSE_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("stego check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define LSE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("stego check failed: next-cycle implication");

`endif

[rtl/lse_pkg.sv]
// ----------------------------------------------------------------------------
// LSB stego package
// Types, codes and helpers shared by the stego embed/extract modules.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int MSG_BITS  = 8;
	localparam int BUF_W     = 16;
	localparam int CNT_W     = 5;
	localparam int BPB_W     = 4;
	localparam int MLEN_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_BPB  = 2'd1,
		REG_MLEN = 2'd2
	} reg_idx_t;

	// Operating modes
	typedef enum logic {
		MODE_EMBED   = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	// Input item selector
	typedef enum logic {
		FUNC_PUSH    = 1'b0,
		FUNC_CARRIER = 1'b1
	} func_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_PASS     = 3'd0,
		KIND_EMBED    = 3'd1,
		KIND_PUSH_OK  = 3'd2,
		KIND_PUSH_REJ = 3'd3,
		KIND_EXTRACT  = 3'd4,
		KIND_COLLECT  = 3'd5
	} kind_t;

	typedef struct packed {
		mode_t               mode;
		logic [BPB_W-1:0]    bpb;
		logic [MLEN_W-1:0]   mlen;
	} cfg_t;

	typedef struct packed {
		logic [BUF_W-1:0]    bit_buf;
		logic [CNT_W-1:0]    bit_cnt;
		logic                last_seen;
		logic                done;
		logic [MLEN_W-1:0]   bytes_out;
	} state_t;

	typedef struct packed {
		logic [MSG_BITS-1:0] out_byte;
		kind_t               kind;
		logic                message_done;
	} res_t;

	// Mask of the low k bits of the bit buffer, k in 0..16
	function automatic logic [BUF_W-1:0] low_mask(input logic [CNT_W-1:0] k);
		logic [BUF_W:0] m;
		m = ({{BUF_W{1'b0}}, 1'b1} << k) - {{BUF_W{1'b0}}, 1'b1};
		return m[BUF_W-1:0];
	endfunction

endpackage

[rtl/lsb_stego_embed_extract.sv]
// Path: an accepted beat is captured in the input register; its result is then
// loaded into the output register, which presents it on the master side.
// Throughput: one item per cycle; the input register and the output register
// pass a beat each cycle whenever the master side takes results.
// Reset (arst_n low): both stages empty, stream state cleared, mode embed,
// bits_per_byte 1, message_length 0. A write to mode also clears stream state.
// ----------------------------------------------------------------------------
// LSB stego embed/extract top level
// Hides message bits in the low bits of carrier bytes, or reads them back.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tuser,    // [0] func
	input  logic        s_tlast,    // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic [3:0]  m_tuser,    // [2:0] kind, [3] message_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lse_pkg::cfg_t cfg;
	lse_pkg::res_t res;
	logic          clr_state;
	logic          res_valid;
	logic          res_ready;

	lse_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (cfg_valid),
		.wr_ready  (cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.cfg       (cfg),
		.clr_state (clr_state)
	);

	lse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clr_state (clr_state),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	lse_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[rtl/lse_cfg.sv]
// ----------------------------------------------------------------------------
// LSB stego configuration registers
// Holds mode, bits per carrier byte and message length; flags a mode write.
// ----------------------------------------------------------------------------
module lse_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	output logic                           wr_ready,
	input  logic [lse_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lse_pkg::CFG_DAT_W-1:0]  wr_data,
	output lse_pkg::cfg_t                  cfg,
	output logic                           clr_state
);

	lse_pkg::cfg_t cfg_q;
	logic          wr_fire;

	assign wr_ready  = 1'b1;
	assign wr_fire   = wr_valid & wr_ready;
	assign clr_state = wr_fire && (wr_index == lse_pkg::REG_MODE);
	assign cfg       = cfg_q;

	// Write the addressed register; stray indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= lse_pkg::MODE_EMBED;
			cfg_q.bpb  <= lse_pkg::BPB_W'(1);
			cfg_q.mlen <= '0;
		end else if (wr_fire) begin
			case (wr_index)
				lse_pkg::REG_MODE: cfg_q.mode <= lse_pkg::mode_t'(wr_data[0]);
				lse_pkg::REG_BPB:  cfg_q.bpb  <= wr_data[lse_pkg::BPB_W-1:0];
				lse_pkg::REG_MLEN: cfg_q.mlen <= wr_data[lse_pkg::MLEN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/lse_core.sv]
// ----------------------------------------------------------------------------
// LSB stego core
// Input register plus one-pass embed/extract logic and the stream state.
// ----------------------------------------------------------------------------
module lse_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lse_pkg::cfg_t                 cfg,
	input  logic                          clr_state,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_func,
	input  logic [lse_pkg::MSG_BITS-1:0]  in_data,
	input  logic                          in_last,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lse_pkg::res_t                 res
);

	logic                          valid_s1;
	logic                          func_s1;
	logic [lse_pkg::MSG_BITS-1:0]  data_s1;
	logic                          last_s1;
	lse_pkg::state_t               st_q;
	lse_pkg::state_t               st_d;
	logic                          advance;

	logic [lse_pkg::BPB_W-1:0]     n;
	logic [lse_pkg::MSG_BITS-1:0]  nmask;
	logic [lse_pkg::CNT_W-1:0]     n_ext;
	logic [lse_pkg::CNT_W-1:0]     cnt_left;
	logic [lse_pkg::BUF_W-1:0]     take_sh;
	logic [lse_pkg::BUF_W-1:0]     tail_sh;
	logic [lse_pkg::BPB_W-1:0]     tail_gap;
	logic [lse_pkg::BUF_W-1:0]     ext_buf;
	logic [lse_pkg::CNT_W-1:0]     ext_cnt;
	logic [lse_pkg::CNT_W-1:0]     ext_left;
	logic [lse_pkg::BUF_W-1:0]     ext_sh;
	logic [lse_pkg::MLEN_W-1:0]    bytes_inc;
	logic                          ext_full;

	assign in_ready  = !valid_s1 || res_ready;
	assign advance   = valid_s1 && res_ready;
	assign res_valid = valid_s1;

	// Capture the accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= in_func;
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	// Clamp n to 1..8 and build its mask
	always_comb begin
		if (cfg.bpb == '0) begin
			n = lse_pkg::BPB_W'(1);
		end else if (cfg.bpb > lse_pkg::BPB_W'(lse_pkg::MSG_BITS)) begin
			n = lse_pkg::BPB_W'(lse_pkg::MSG_BITS);
		end else begin
			n = cfg.bpb;
		end
		nmask = 8'hFF >> (lse_pkg::BPB_W'(lse_pkg::MSG_BITS) - n);
		n_ext = {1'b0, n};
	end

	// Datapath terms for both modes
	always_comb begin
		cnt_left  = st_q.bit_cnt - n_ext;
		take_sh   = st_q.bit_buf >> cnt_left;
		tail_gap  = n - st_q.bit_cnt[lse_pkg::BPB_W-1:0];
		tail_sh   = (st_q.bit_buf & lse_pkg::low_mask(st_q.bit_cnt)) << tail_gap;
		ext_buf   = (st_q.bit_buf << n) | {8'h00, data_s1 & nmask};
		ext_cnt   = st_q.bit_cnt + n_ext;
		ext_full  = ext_cnt >= lse_pkg::CNT_W'(lse_pkg::MSG_BITS);
		ext_left  = ext_cnt - lse_pkg::CNT_W'(lse_pkg::MSG_BITS);
		ext_sh    = ext_buf >> ext_left;
		bytes_inc = st_q.bytes_out + lse_pkg::MLEN_W'(1);
	end

	// Next state and result for the item in the input register
	always_comb begin
		st_d             = st_q;
		res.out_byte     = '0;
		res.kind         = lse_pkg::KIND_PASS;
		if (cfg.mode == lse_pkg::MODE_EMBED) begin
			if (func_s1 == lse_pkg::FUNC_PUSH) begin
				if (st_q.bit_cnt > lse_pkg::CNT_W'(lse_pkg::MSG_BITS) || st_q.last_seen) begin
					res.kind = lse_pkg::KIND_PUSH_REJ;
				end else begin
					st_d.bit_buf   = {st_q.bit_buf[lse_pkg::MSG_BITS-1:0], data_s1};
					st_d.bit_cnt   = st_q.bit_cnt + lse_pkg::CNT_W'(lse_pkg::MSG_BITS);
					st_d.last_seen = st_q.last_seen | last_s1;
					st_d.done      = 1'b0;
					res.kind       = lse_pkg::KIND_PUSH_OK;
				end
			end else begin
				if (st_q.bit_cnt >= n_ext) begin
					st_d.bit_cnt = cnt_left;
					st_d.bit_buf = st_q.bit_buf & lse_pkg::low_mask(cnt_left);
					res.out_byte = (data_s1 & ~nmask) | (take_sh[7:0] & nmask);
					res.kind     = lse_pkg::KIND_EMBED;
				end else if (st_q.last_seen && st_q.bit_cnt != '0) begin
					st_d.bit_cnt = '0;
					st_d.bit_buf = '0;
					res.out_byte = (data_s1 & ~nmask) | (tail_sh[7:0] & nmask);
					res.kind     = lse_pkg::KIND_EMBED;
				end else begin
					res.out_byte = data_s1;
				end
				if (st_q.last_seen && st_d.bit_cnt == '0) begin
					st_d.done = 1'b1;
				end
			end
		end else begin
			if (func_s1 == lse_pkg::FUNC_PUSH) begin
				res.kind = lse_pkg::KIND_PUSH_REJ;
			end else if (st_q.bytes_out >= cfg.mlen) begin
				res.out_byte = data_s1;
			end else if (ext_full) begin
				st_d.bytes_out = bytes_inc;
				res.out_byte   = ext_sh[7:0];
				res.kind       = lse_pkg::KIND_EXTRACT;
				if (bytes_inc >= cfg.mlen) begin
					st_d.bit_buf = '0;
					st_d.bit_cnt = '0;
				end else begin
					st_d.bit_buf = ext_buf & lse_pkg::low_mask(ext_left);
					st_d.bit_cnt = ext_left;
				end
			end else begin
				st_d.bit_buf = ext_buf;
				st_d.bit_cnt = ext_cnt;
				res.kind     = lse_pkg::KIND_COLLECT;
			end
			st_d.done = st_d.bytes_out >= cfg.mlen;
		end
		res.message_done = st_d.done;
	end

	// Commit state as the result moves on; a mode write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (clr_state) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

endmodule

[rtl/lse_out.sv]
// ----------------------------------------------------------------------------
// LSB stego output register
// Holds one result beat for the master side and frees as it is taken.
// ----------------------------------------------------------------------------
module lse_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	output logic           res_ready,
	input  lse_pkg::res_t  res,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic [3:0]     m_tuser
);

	logic          valid_q;
	lse_pkg::res_t res_q;

	assign res_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = res_q.out_byte;
	assign m_tuser   = {res_q.message_done, res_q.kind};

	// Load when empty or draining; hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

[rtl/lse_chk.sv]
// ----------------------------------------------------------------------------
// LSB stego port checker
// Watches the top-level ports for result beats that break the block's rules.
// ----------------------------------------------------------------------------
`include "lsb_stego_embed_extract_defines.svh"

module lse_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [3:0]  m_tuser
);

	logic [2:0] out_kind;
	logic       out_stall;
	logic       zero_kind;

	assign out_kind  = m_tuser[2:0];
	assign out_stall = m_tvalid && !m_tready;
	assign zero_kind = out_kind == lse_pkg::KIND_PUSH_OK || out_kind == lse_pkg::KIND_PUSH_REJ
		|| out_kind == lse_pkg::KIND_COLLECT;

	// A stalled result beat holds
	`LSE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Pushes and collecting beats carry a zero byte
	`LSE_ASSERT_IMPLY(a_zero_byte, clk, arst_n, m_tvalid && zero_kind, m_tdata == 8'h00)

	// An accepted push reopens the message
	`LSE_ASSERT_IMPLY(a_push_not_done, clk, arst_n, m_tvalid && out_kind == lse_pkg::KIND_PUSH_OK, !m_tuser[3])

	// Still collecting means the message is not complete
	`LSE_ASSERT_IMPLY(a_collect_not_done, clk, arst_n, m_tvalid && out_kind == lse_pkg::KIND_COLLECT, !m_tuser[3])

endmodule

bind lsb_stego_embed_extract lse_chk u_lse_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// LSB stego embed/extract testbench
// Drives message pushes and carrier bytes through the slave stream, predicts
// every master beat with a cycle-free shadow of the block state, and checks
// each beat field by field. Runs directed embed and extract cases, then random
// phases with random register writes and random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lse_pkg::CFG_IDX_W-1:0] REG_STRAY = 2'd3;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_AFTER   = 950;

	// Shadow of the block: register copy, stream state and expected beats
	class stego_shadow;
		lse_pkg::mode_t                mode;
		logic [lse_pkg::BPB_W-1:0]     bpb;
		logic [lse_pkg::MLEN_W-1:0]    mlen;
		logic [lse_pkg::BUF_W-1:0]     bit_buf;
		logic [lse_pkg::CNT_W-1:0]     bit_cnt;
		logic                          last_seen;
		logic                          done;
		logic [lse_pkg::MLEN_W-1:0]    bytes_out;
		lse_pkg::res_t                 due[$];
		int                            errors;

		function new();
			mode = lse_pkg::MODE_EMBED;
			bpb = 4'd1;
			mlen = '0;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			bit_buf = '0;
			bit_cnt = '0;
			last_seen = 1'b0;
			done = 1'b0;
			bytes_out = '0;
		endfunction

		// Effective carrier bits: 0 counts as 1, above 8 counts as 8
		function int unsigned width();
			if (bpb == 0) return 1;
			if (bpb > 8) return 8;
			return bpb;
		endfunction

		function logic [lse_pkg::BUF_W-1:0] low_bits(int unsigned k);
			return lse_pkg::BUF_W'((32'd1 << k) - 1);
		endfunction

		function void set_reg(logic [lse_pkg::CFG_IDX_W-1:0] idx,
				logic [lse_pkg::CFG_DAT_W-1:0] v);
			case (idx)
				lse_pkg::REG_MODE: begin
					mode = lse_pkg::mode_t'(v[0]);
					clear_stream();
				end
				lse_pkg::REG_BPB:  bpb = v[lse_pkg::BPB_W-1:0];
				lse_pkg::REG_MLEN: mlen = v[lse_pkg::MLEN_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the shadow by one accepted slave beat and queue its result
		function void absorb(lse_pkg::func_t f, logic [7:0] d, logic l);
			lse_pkg::res_t r;
			int unsigned   n;
			logic [7:0]    nm;
			logic [7:0]    chunk;
			n = width();
			nm = 8'((32'd1 << n) - 1);
			r.out_byte = '0;
			r.kind = lse_pkg::KIND_PASS;
			if (mode == lse_pkg::MODE_EMBED) begin
				if (f == lse_pkg::FUNC_PUSH) begin
					if (bit_cnt > 8 || last_seen) begin
						r.kind = lse_pkg::KIND_PUSH_REJ;
					end else begin
						bit_buf = {bit_buf[7:0], d};
						bit_cnt = bit_cnt + 5'd8;
						if (l) last_seen = 1'b1;
						done = 1'b0;
						r.kind = lse_pkg::KIND_PUSH_OK;
					end
				end else begin
					if (bit_cnt >= n) begin
						chunk = 8'(bit_buf >> (bit_cnt - n)) & nm;
						bit_cnt = lse_pkg::CNT_W'(bit_cnt - n);
						bit_buf = bit_buf & low_bits(bit_cnt);
						r.out_byte = (d & ~nm) | chunk;
						r.kind = lse_pkg::KIND_EMBED;
					end else if (last_seen && bit_cnt != 0) begin
						// tail chunk goes out left-aligned, zero filled
						chunk = 8'(bit_buf << (n - bit_cnt)) & nm;
						bit_cnt = '0;
						bit_buf = '0;
						r.out_byte = (d & ~nm) | chunk;
						r.kind = lse_pkg::KIND_EMBED;
					end else begin
						r.out_byte = d;
					end
					if (last_seen && bit_cnt == 0) done = 1'b1;
				end
			end else begin
				if (f == lse_pkg::FUNC_PUSH) begin
					r.kind = lse_pkg::KIND_PUSH_REJ;
				end else if (bytes_out >= mlen) begin
					r.out_byte = d;
				end else begin
					bit_buf = lse_pkg::BUF_W'((32'(bit_buf) << n) | 32'(d & nm));
					bit_cnt = lse_pkg::CNT_W'(bit_cnt + n);
					if (bit_cnt >= lse_pkg::MSG_BITS) begin
						r.out_byte = 8'(bit_buf >> (bit_cnt - lse_pkg::MSG_BITS));
						bit_cnt = lse_pkg::CNT_W'(bit_cnt - lse_pkg::MSG_BITS);
						bit_buf = bit_buf & low_bits(bit_cnt);
						bytes_out = bytes_out + 16'd1;
						r.kind = lse_pkg::KIND_EXTRACT;
						// surplus bits of the final carrier are dropped
						if (bytes_out >= mlen) begin
							bit_buf = '0;
							bit_cnt = '0;
						end
					end else begin
						r.kind = lse_pkg::KIND_COLLECT;
					end
				end
				done = (bytes_out >= mlen);
			end
			r.message_done = done;
			due.push_back(r);
		endfunction

		task flag(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Compare one master beat against the oldest expected result
		task match(logic [7:0] ob, logic [3:0] user);
			lse_pkg::res_t e;
			if (due.size() == 0) begin
				flag($sformatf("unexpected beat, byte %02h user %h", ob, user));
				return;
			end
			e = due.pop_front();
			if (ob !== e.out_byte)
				flag($sformatf("out_byte %02h, expected %02h", ob, e.out_byte));
			if (user[2:0] !== e.kind)
				flag($sformatf("kind %0d, expected %s", user[2:0], e.kind.name()));
			if (user[3] !== e.message_done)
				flag($sformatf("message_done %b, expected %b", user[3], e.message_done));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] data_byte
	logic        s_tuser = 1'b0;  // [0] func
	logic        s_tlast = 1'b0;  // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] out_byte
	logic [3:0]  m_tuser;         // [2:0] kind, [3] message_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	stego_shadow shadow = new();
	logic        calm = 1'b0;
	int unsigned cycles = 0;
	int          hold_left = 0;

	lsb_stego_embed_extract uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stall the master side in bursts, starting none once the run has gone calm
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			hold_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
			hold_left <= $urandom_range(0, 24);
		end
	end

	// Sample between edges; a beat seen here is taken at the next rising edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) shadow.match(m_tdata, m_tuser);
	end

	// Present one slave beat and hold it until taken
	task automatic send_beat(input lse_pkg::func_t f, input logic [7:0] d, input logic l);
		logic took;
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= d;
		s_tlast <= l;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		shadow.absorb(f, d, l);
	endtask

	task automatic load_reg(input logic [lse_pkg::CFG_IDX_W-1:0] idx,
			input logic [lse_pkg::CFG_DAT_W-1:0] v);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		shadow.set_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected beat is back, then let the pipe empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (shadow.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int         sent;
		int         burst;
		logic [3:0] w;
		logic [15:0] len;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Embed at reset width: underrun, two pushes fill the buffer, third bounces
		send_beat(lse_pkg::FUNC_CARRIER, 8'h5A, 1'b0);
		send_beat(lse_pkg::FUNC_PUSH, 8'hFF, 1'b0);
		send_beat(lse_pkg::FUNC_PUSH, 8'h00, 1'b0);
		send_beat(lse_pkg::FUNC_PUSH, 8'h81, 1'b1);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h00, 1'b1);

		// Widen to three bits mid-message; final byte, late push, tail flush
		settle();
		load_reg(lse_pkg::REG_BPB, 16'hFFF3);
		send_beat(lse_pkg::FUNC_CARRIER, 8'hFF, 1'b0);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h00, 1'b0);
		send_beat(lse_pkg::FUNC_PUSH, 8'hC3, 1'b1);
		send_beat(lse_pkg::FUNC_CARRIER, 8'hA5, 1'b0);
		send_beat(lse_pkg::FUNC_PUSH, 8'h3C, 1'b1);
		send_beat(lse_pkg::FUNC_PUSH, 8'h11, 1'b0);
		repeat (6) send_beat(lse_pkg::FUNC_CARRIER, 8'hFF, 1'b0);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h00, 1'b1);

		// Extract with width above range, push rejected, echo after completion
		settle();
		load_reg(lse_pkg::REG_MODE, 16'hFFFF);
		load_reg(lse_pkg::REG_BPB, 16'h000F);
		load_reg(lse_pkg::REG_MLEN, 16'd2);
		send_beat(lse_pkg::FUNC_PUSH, 8'h77, 1'b1);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h12, 1'b0);
		send_beat(lse_pkg::FUNC_CARRIER, 8'hFF, 1'b1);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h00, 1'b0);

		// Zero length is complete from the start
		settle();
		load_reg(lse_pkg::REG_MLEN, 16'd0);
		send_beat(lse_pkg::FUNC_CARRIER, 8'hC9, 1'b0);

		// Mode write clears; three-bit carriers leave a surplus bit
		settle();
		load_reg(lse_pkg::REG_MODE, 16'h0001);
		load_reg(lse_pkg::REG_BPB, 16'h0003);
		load_reg(lse_pkg::REG_MLEN, 16'd1);
		repeat (3) send_beat(lse_pkg::FUNC_CARRIER, 8'hB6, 1'b0);

		// Stray index changes nothing; longest length keeps collecting
		settle();
		load_reg(REG_STRAY, 16'hFFFF);
		load_reg(lse_pkg::REG_MLEN, 16'hFFFF);
		load_reg(lse_pkg::REG_BPB, 16'h0000);
		send_beat(lse_pkg::FUNC_CARRIER, 8'hFF, 1'b0);
		send_beat(lse_pkg::FUNC_CARRIER, 8'h01, 1'b0);

		// Random phases, each may start with fresh settings
		while (sent < RANDOM_ITEMS) begin
			settle();
			if ($urandom_range(0, 1) == 0) load_reg(lse_pkg::REG_MODE, 16'($urandom));
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
					0: w = 4'd0;
					1: w = 4'd1;
					2: w = 4'd8;
					3: w = 4'($urandom_range(9, 15));
					default: w = 4'($urandom_range(1, 8));
				endcase
				load_reg(lse_pkg::REG_BPB, {12'($urandom), w});
			end
			if (shadow.mode == lse_pkg::MODE_EXTRACT || $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 15))
					0: len = 16'd0;
					1: len = 16'hFFFF;
					default: len = 16'($urandom_range(1, 12));
				endcase
				load_reg(lse_pkg::REG_MLEN, len);
			end
			if ($urandom_range(0, 9) == 0) load_reg(REG_STRAY, 16'($urandom));
			burst = $urandom_range(20, 150);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				if (sent >= CALM_AFTER) calm = 1'b1;
				if (i == burst / 2 && $urandom_range(0, 3) == 0) settle();
				maybe_pause();
				if ($urandom_range(0, 9) == 0) begin
					// noise: anything the fields allow
					send_beat(lse_pkg::func_t'($urandom_range(0, 1)), 8'($urandom),
						1'($urandom_range(0, 1)));
				end else if (shadow.mode == lse_pkg::MODE_EMBED && !shadow.last_seen
						&& shadow.bit_cnt <= lse_pkg::MSG_BITS
						&& (shadow.bit_cnt < shadow.width() || $urandom_range(0, 2) == 0)) begin
					send_beat(lse_pkg::FUNC_PUSH, 8'($urandom), $urandom_range(0, 7) == 0);
				end else begin
					send_beat(lse_pkg::FUNC_CARRIER, 8'($urandom), 1'($urandom_range(0, 1)));
				end
				sent++;
			end
		end

		// Wind down
		calm = 1'b1;
		settle();
		repeat (10) @(posedge clk);
		if (shadow.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_cfg.sv
rtl/lse_core.sv
rtl/lse_out.sv
rtl/lsb_stego_embed_extract.sv
rtl/lse_chk.sv
test/tb_top.sv
